/* design/pct_pkg.sv */
// Shared types, constants and helpers for the peer contact table.
`default_nettype none
package pct_pkg;

  localparam int INDEX_BITS = 12;
  localparam int CELLS      = 1 << INDEX_BITS;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [4:0]  MAX_Q_RST = 5'd15;
  localparam logic [15:0] PORT_MIN  = 16'd1024;

  typedef logic [INDEX_BITS-1:0] idx_t;

  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_REPLACE = 3'd1,
    MODE_ADJUST  = 3'd2,
    MODE_LOOKUP  = 3'd3,
    MODE_REMOVE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_INVALID  = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] id_high;
    logic [63:0] id_middle;
    logic [31:0] id_low;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [7:0]  base_quality;
    logic signed [7:0] quality_delta;
    logic [31:0] random_bits;
  } pct_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] found_id_high;
    logic [63:0] found_id_middle;
    logic [31:0] found_id_low;
    logic [31:0] found_address;
    logic [15:0] found_port;
    logic [4:0]  found_quality;
    logic [23:0] cell_index;
  } pct_out_t;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_middle;
    logic [31:0] id_low;
    logic [31:0] address;
    logic [15:0] port;
    logic [4:0]  quality;
  } pct_cell_t;

  function automatic logic [4:0] clip_q(input logic [7:0] v, input logic [4:0] mx);
    return (v > {3'b000, mx}) ? mx : v[4:0];
  endfunction

endpackage
`default_nettype wire

/* design/pct_ram.sv */
// Contact store: one write port, one read port with registered read data.
`default_nettype none
module pct_ram (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire pct_pkg::idx_t     wr_addr,
  input  wire pct_pkg::pct_cell_t wr_data,
  input  wire pct_pkg::idx_t     rd_addr,
  output pct_pkg::pct_cell_t     rd_data
);
  import pct_pkg::*;

  pct_cell_t mem [CELLS];
  pct_cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* design/pct_addr_chk.sv */
// Peer address and port validity check against reserved IPv4 ranges.
`default_nettype none
module pct_addr_chk (
  input  wire logic [31:0] addr,
  input  wire logic [15:0] port,
  output logic             ok
);
  import pct_pkg::*;

  logic [7:0] a, b, c;
  logic       bad_port, bad_a, bad_ab, bad_abc, bad_bcast;

  assign a = addr[31:24];
  assign b = addr[23:16];
  assign c = addr[15:8];

  always_comb begin
    bad_port  = (port <= PORT_MIN);
    bad_a     = ((a & 8'hf0) == 8'd240) || (a == 8'd0) || (a == 8'd10) || (a == 8'd127);
    bad_ab    = ((a == 8'd100) && ((b & 8'hc0) == 8'd64)) ||
                ((a == 8'd172) && ((b & 8'hf0) == 8'd16)) ||
                ((a == 8'd198) && ((b & 8'hfe) == 8'd18)) ||
                ((a == 8'd169) && (b == 8'd254)) ||
                ((a == 8'd192) && (b == 8'd168));
    bad_abc   = ((a == 8'd192) && (b == 8'd0) && ((c == 8'd0) || (c == 8'd2))) ||
                ((a == 8'd192) && (b == 8'd31) && (c == 8'd196)) ||
                ((a == 8'd192) && (b == 8'd51) && (c == 8'd100)) ||
                ((a == 8'd192) && (b == 8'd52) && (c == 8'd193)) ||
                ((a == 8'd192) && (b == 8'd175) && (c == 8'd48)) ||
                ((a == 8'd198) && (b == 8'd51) && (c == 8'd100)) ||
                ((a == 8'd203) && (b == 8'd0) && (c == 8'd113));
    bad_bcast = (addr == 32'hffff_ffff);
    ok        = !(bad_port || bad_a || bad_ab || bad_abc || bad_bcast);
  end

endmodule
`default_nettype wire

/* design/pct_cfg.sv */
// APB register block holding the quality clip bound.
`default_nettype none
module pct_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [pct_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [pct_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pct_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready,
  output logic [4:0]                      max_q
);
  import pct_pkg::*;

  logic [4:0] max_q_r;
  logic       wr;

  // single word register: byte offset bits do not select
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == cfg_paddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_q_r <= MAX_Q_RST;
    end else if (wr) begin
      max_q_r <= cfg_pwdata[4:0];
    end
  end

  assign cfg_prdata = {{(CFG_DW-5){1'b0}}, max_q_r};
  assign cfg_pready = 1'b1;
  assign max_q      = max_q_r;

endmodule
`default_nettype wire

/* design/peer_contact_table.sv */
// Top level of the peer contact table: request sequencer around the contact store.
`default_nettype none
// A request is taken when start is high and busy is low. Busy stays high while the addressed
// cell is read from the store and then written back in S_EVAL; a neighbour lookup that finds
// its cell empty reads the neighbour cell too, in S_EVAL2. The result appears with out_valid
// for exactly one cycle, the cycle in which busy falls; it cannot be held off, so capture it
// then. After reset busy stays high while every cell of the store is cleared; the max_quality
// register can be written at any time the block is idle.
module peer_contact_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire pct_pkg::pct_in_t           in_req,
  output logic                            out_valid,
  output pct_pkg::pct_out_t               out_res,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [pct_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [pct_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pct_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import pct_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_EVAL2 = 4'b1000
  } state_t;

  state_t    state_r, state_nxt;
  idx_t      clr_r, clr_nxt;
  pct_in_t   req_r;
  logic      out_valid_r, out_valid_nxt;
  pct_out_t  out_res_r, out_res_nxt;

  logic      accept;
  logic      wr_en;
  idx_t      wr_addr, rd_addr, req_ix, alt_ix;
  pct_cell_t wr_data, rd_data, new_cell;
  logic [4:0] max_q;
  logic      addr_ok, evict, id_match;
  logic [4:0] diff;
  logic [31:0] mask;
  logic [7:0] adj_q;

  pct_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_q       (max_q)
  );

  pct_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pct_addr_chk u_chk (
    .addr (req_r.peer_address),
    .port (req_r.peer_port),
    .ok   (addr_ok)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign req_ix = req_r.id_high[63 -: INDEX_BITS];
  assign alt_ix = req_ix ^ idx_t'(1);

  always_comb begin
    diff     = rd_data.quality - req_r.base_quality[4:0];
    mask     = ~(32'hffff_ffff << diff);
    evict    = (req_r.base_quality >= {3'b000, rd_data.quality}) ||
               ((req_r.random_bits & mask) == 32'd0);
    id_match = (rd_data.id_high == req_r.id_high) &&
               (rd_data.id_middle == req_r.id_middle) &&
               (rd_data.id_low == req_r.id_low);
    adj_q    = {3'b000, rd_data.quality} + req_r.quality_delta;
    new_cell = '{id_high:   req_r.id_high,
                 id_middle: req_r.id_middle,
                 id_low:    req_r.id_low,
                 address:   req_r.peer_address,
                 port:      req_r.peer_port,
                 quality:   clip_q(req_r.base_quality, max_q)};
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    wr_en         = 1'b0;
    wr_addr       = req_ix;
    wr_data       = rd_data;
    rd_addr       = in_req.id_high[63 -: INDEX_BITS];
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + idx_t'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt              = S_IDLE;
        out_valid_nxt          = 1'b1;
        out_res_nxt            = '0;
        out_res_nxt.status     = ST_DONE;
        out_res_nxt.cell_index = 24'(req_ix);
        unique case (req_r.mode)
          MODE_ADD: begin
            if (!addr_ok) begin
              out_res_nxt.status = ST_INVALID;
            end else if (!evict) begin
              out_res_nxt.status = ST_REJECTED;
            end else begin
              wr_en              = 1'b1;
              wr_data            = new_cell;
              out_res_nxt.status = ST_ACCEPTED;
            end
          end
          MODE_REPLACE: begin
            if (!evict) begin
              out_res_nxt.status = ST_REJECTED;
            end else if (req_r.id_high == 64'd0 || !addr_ok) begin
              out_res_nxt.status = ST_INVALID;
            end else begin
              wr_en              = 1'b1;
              wr_data            = new_cell;
              out_res_nxt.status = ST_ACCEPTED;
            end
          end
          MODE_ADJUST: begin
            if (id_match) begin
              wr_en           = 1'b1;
              wr_data.quality = clip_q(adj_q, max_q);
            end
          end
          MODE_LOOKUP: begin
            if (rd_data.id_high != 64'd0) begin
              out_res_nxt.hit             = 1'b1;
              out_res_nxt.found_id_high   = rd_data.id_high;
              out_res_nxt.found_id_middle = rd_data.id_middle;
              out_res_nxt.found_id_low    = rd_data.id_low;
              out_res_nxt.found_address   = rd_data.address;
              out_res_nxt.found_port      = rd_data.port;
              out_res_nxt.found_quality   = rd_data.quality;
            end else begin
              // own cell empty: try the neighbour
              out_valid_nxt = 1'b0;
              rd_addr       = alt_ix;
              state_nxt     = S_EVAL2;
            end
          end
          MODE_REMOVE: begin
            if (id_match) begin
              wr_en   = 1'b1;
              wr_data = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_EVAL2: begin
        state_nxt              = S_IDLE;
        out_valid_nxt          = 1'b1;
        out_res_nxt            = '0;
        out_res_nxt.status     = ST_DONE;
        out_res_nxt.cell_index = 24'(req_ix);
        if (rd_data.id_high != 64'd0) begin
          out_res_nxt.hit             = 1'b1;
          out_res_nxt.cell_index      = 24'(alt_ix);
          out_res_nxt.found_id_high   = rd_data.id_high;
          out_res_nxt.found_id_middle = rd_data.id_middle;
          out_res_nxt.found_id_low    = rd_data.id_low;
          out_res_nxt.found_address   = rd_data.address;
          out_res_nxt.found_port      = rd_data.port;
          out_res_nxt.found_quality   = rd_data.quality;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (accept) begin
      req_r <= in_req;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

/* bench/peer_contact_table_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the peer contact table: predicted contact-table results against the block.
import pct_pkg::*;

class contact_tracker;
  pct_cell_t  cells [CELLS];
  logic [4:0] max_quality;
  pct_out_t   expected_results [$];
  int         errors;

  function new();
    foreach (cells[i]) cells[i] = '0;
    max_quality = MAX_Q_RST;
    errors = 0;
  endfunction

  function void set_max_quality(input logic [4:0] value);
    max_quality = value;
  endfunction

  function logic [4:0] clip(input logic [7:0] value);
    return (value > {3'b000, max_quality}) ? max_quality : value[4:0];
  endfunction

  function bit address_valid(input logic [31:0] addr, input logic [15:0] port);
    logic [7:0] a, b, c;
    a = addr[31:24];
    b = addr[23:16];
    c = addr[15:8];
    if (port <= PORT_MIN) return 1'b0;
    // first octet 240..255 also covers the broadcast address
    if (a[7:4] == 4'hf || a == 8'd0 || a == 8'd10 || a == 8'd127) return 1'b0;
    if ((a == 8'd100 && b[7:6] == 2'b01) || (a == 8'd172 && b[7:4] == 4'h1) ||
        (a == 8'd198 && b[7:1] == 7'd9) || (a == 8'd169 && b == 8'd254) ||
        (a == 8'd192 && b == 8'd168)) return 1'b0;
    if ((a == 8'd192 && b == 8'd0 && (c == 8'd0 || c == 8'd2)) ||
        (a == 8'd192 && b == 8'd31 && c == 8'd196) ||
        (a == 8'd192 && b == 8'd51 && c == 8'd100) ||
        (a == 8'd192 && b == 8'd52 && c == 8'd193) ||
        (a == 8'd192 && b == 8'd175 && c == 8'd48) ||
        (a == 8'd198 && b == 8'd51 && c == 8'd100) ||
        (a == 8'd203 && b == 8'd0 && c == 8'd113)) return 1'b0;
    return 1'b1;
  endfunction

  function bit evicts(input logic [4:0] cur, input logic [7:0] cand, input logic [31:0] rnd);
    logic [4:0]  d;
    logic [31:0] mask;
    if (cand >= {3'b000, cur}) return 1'b1;
    d = cur - cand[4:0];
    mask = (32'd1 << d) - 32'd1;
    return (rnd & mask) == 32'd0;
  endfunction

  function void store_contact(input idx_t ix, input pct_in_t req);
    cells[ix].id_high   = req.id_high;
    cells[ix].id_middle = req.id_middle;
    cells[ix].id_low    = req.id_low;
    cells[ix].address   = req.peer_address;
    cells[ix].port      = req.peer_port;
    cells[ix].quality   = clip(req.base_quality);
  endfunction

  function void note_request(input pct_in_t req);
    pct_out_t   res;
    idx_t       ix, used, alt;
    logic [7:0] sum;
    bit         same_id;
    res = '0;
    ix = req.id_high[63 -: INDEX_BITS];
    alt = ix ^ idx_t'(1);
    used = ix;
    res.status = ST_DONE;
    same_id = cells[ix].id_high == req.id_high && cells[ix].id_middle == req.id_middle &&
              cells[ix].id_low == req.id_low;
    case (req.mode)
      MODE_ADD: begin
        if (!address_valid(req.peer_address, req.peer_port)) begin
          res.status = ST_INVALID;
        end else if (!evicts(cells[ix].quality, req.base_quality, req.random_bits)) begin
          res.status = ST_REJECTED;
        end else begin
          store_contact(ix, req);
          res.status = ST_ACCEPTED;
        end
      end
      MODE_REPLACE: begin
        if (!evicts(cells[ix].quality, req.base_quality, req.random_bits)) begin
          res.status = ST_REJECTED;
        end else if (req.id_high == 64'd0 ||
                     !address_valid(req.peer_address, req.peer_port)) begin
          res.status = ST_INVALID;
        end else begin
          store_contact(ix, req);
          res.status = ST_ACCEPTED;
        end
      end
      MODE_ADJUST: begin
        if (same_id) begin
          sum = {3'b000, cells[ix].quality} + $unsigned(req.quality_delta);
          cells[ix].quality = clip(sum);
        end
      end
      MODE_LOOKUP: begin
        if (cells[ix].id_high != 64'd0) begin
          res.hit = 1'b1;
        end else if (cells[alt].id_high != 64'd0) begin
          res.hit = 1'b1;
          used = alt;
        end
        if (res.hit) begin
          res.found_id_high   = cells[used].id_high;
          res.found_id_middle = cells[used].id_middle;
          res.found_id_low    = cells[used].id_low;
          res.found_address   = cells[used].address;
          res.found_port      = cells[used].port;
          res.found_quality   = cells[used].quality;
        end
      end
      MODE_REMOVE: begin
        if (same_id) cells[ix] = '0;
      end
      default: ;
    endcase
    res.cell_index = 24'(used);
    expected_results.push_back(res);
  endfunction

  function void compare_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(input pct_out_t got);
    pct_out_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result with no request outstanding: %h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("hit", want.hit, got.hit);
    compare_field("found_id_high", want.found_id_high, got.found_id_high);
    compare_field("found_id_middle", want.found_id_middle, got.found_id_middle);
    compare_field("found_id_low", want.found_id_low, got.found_id_low);
    compare_field("found_address", want.found_address, got.found_address);
    compare_field("found_port", want.found_port, got.found_port);
    compare_field("found_quality", want.found_quality, got.found_quality);
    compare_field("cell_index", want.cell_index, got.cell_index);
  endfunction
endclass

module peer_contact_table_tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int POOL_SIZE      = 24;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 140;
  localparam int PHASE_IDLE [PHASES]    = '{0, 49, 9, 49, 0, 9};
  localparam int PHASE_QUALITY [PHASES] = '{0, 31, 7, -1, 1, 15};  // -1: random

  localparam logic [CFG_AW-1:0] REG_MAX_QUALITY = '0;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;

  localparam logic [31:0] GOOD_ADDR      = 32'h5db8_d822;
  localparam logic [15:0] GOOD_PORT      = 16'd6881;
  localparam logic [63:0] ID_A_HIGH      = 64'h004a_1111_2222_3333;
  localparam logic [63:0] ID_B_HIGH      = 64'h0040_0000_0000_0001;
  localparam logic [63:0] NEIGHBOUR_HIGH = 64'h0050_0000_0000_0001;
  localparam logic [63:0] ID_MID         = 64'h0123_4567_89ab_cdef;
  localparam logic [31:0] ID_LOW         = 32'hdead_beef;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  pct_in_t             in_req;
  logic                out_valid;
  pct_out_t            out_res;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  contact_tracker tracker;
  int             sender_idle_pct = 0;
  int             quiet_cycles = 0;
  idx_t           hot_cells [8];
  logic [63:0]    pool_high [POOL_SIZE];
  logic [63:0]    pool_middle [POOL_SIZE];
  logic [31:0]    pool_low [POOL_SIZE];

  peer_contact_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) tracker.check_result(out_res);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no progress", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic pct_in_t make_req(input logic [2:0] mode, input logic [63:0] hi,
                                       input logic [63:0] mid, input logic [31:0] lo,
                                       input logic [31:0] addr, input logic [15:0] port,
                                       input logic [7:0] base, input logic signed [7:0] delta,
                                       input logic [31:0] rnd);
    pct_in_t req;
    req.mode          = mode;
    req.id_high       = hi;
    req.id_middle     = mid;
    req.id_low        = lo;
    req.peer_address  = addr;
    req.peer_port     = port;
    req.base_quality  = base;
    req.quality_delta = delta;
    req.random_bits   = rnd;
    return req;
  endfunction

  function automatic logic [31:0] reserved_address();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 18))
      0:  return {8'd0, r[23:0]};
      1:  return {8'd10, r[23:0]};
      2:  return {8'd127, r[23:0]};
      3:  return {4'hf, r[27:0]};
      4:  return {8'd100, 2'b01, r[21:0]};
      5:  return {8'd172, 4'h1, r[19:0]};
      6:  return {8'd198, 7'd9, r[16:0]};
      7:  return {8'd169, 8'd254, r[15:0]};
      8:  return {8'd192, 8'd168, r[15:0]};
      9:  return {8'd192, 8'd0, 8'd0, r[7:0]};
      10: return {8'd192, 8'd0, 8'd2, r[7:0]};
      11: return {8'd192, 8'd31, 8'd196, r[7:0]};
      12: return {8'd192, 8'd51, 8'd100, r[7:0]};
      13: return {8'd192, 8'd52, 8'd193, r[7:0]};
      14: return {8'd192, 8'd175, 8'd48, r[7:0]};
      15: return {8'd198, 8'd51, 8'd100, r[7:0]};
      16: return {8'd203, 8'd0, 8'd113, r[7:0]};
      17: return 32'hffff_ffff;
      default: return {8'd192, 8'd0, 8'd3, r[7:0]};  // near miss, valid
    endcase
  endfunction

  function automatic pct_in_t random_request();
    pct_in_t req;
    int      pick;
    int      k;
    pick = $urandom_range(0, 99);
    if (pick < 30)      req.mode = MODE_ADD;
    else if (pick < 50) req.mode = MODE_REPLACE;
    else if (pick < 65) req.mode = MODE_ADJUST;
    else if (pick < 85) req.mode = MODE_LOOKUP;
    else if (pick < 96) req.mode = MODE_REMOVE;
    else req.mode = 3'($urandom_range(int'(MODE_REMOVE) + 1, int'(MODE_UNUSED)));

    pick = $urandom_range(0, 99);
    k = $urandom_range(0, POOL_SIZE - 1);
    if (pick < 75) begin
      req.id_high   = pool_high[k];
      req.id_middle = pool_middle[k];
      req.id_low    = pool_low[k];
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1) == 0) req.id_low = req.id_low ^ (32'd1 << $urandom_range(0, 31));
        else req.id_middle = {$urandom, $urandom};
      end
    end else begin
      req.id_high   = (pick < 97) ? {$urandom, $urandom} : 64'd0;
      req.id_middle = {$urandom, $urandom};
      req.id_low    = $urandom;
    end

    pick = $urandom_range(0, 99);
    if (pick < 70)      req.peer_address = {8'($urandom_range(1, 223)), 24'($urandom)};
    else if (pick < 90) req.peer_address = reserved_address();
    else                req.peer_address = $urandom;

    pick = $urandom_range(0, 99);
    if (pick < 80)      req.peer_port = 16'($urandom_range(int'(PORT_MIN) + 1, 65535));
    else if (pick < 90) req.peer_port = PORT_MIN + 16'($urandom_range(0, 1));
    else                req.peer_port = 16'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 50)      req.base_quality = 8'($urandom_range(0, 31));
    else if (pick < 85) req.base_quality = 8'($urandom);
    else                req.base_quality = 8'($urandom_range(0, 3));

    req.quality_delta = 8'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 45)      req.random_bits = $urandom << $urandom_range(1, 31);
    else if (pick < 50) req.random_bits = 32'd0;
    else                req.random_bits = $urandom;
    return req;
  endfunction

  task automatic send_request(input pct_in_t req);
    in_req <= req;
    start  <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(req);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_quality(input logic [4:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_MAX_QUALITY;
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_max_quality(value);
  endtask

  initial begin
    tracker = new();
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req      <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;

    // crowded cells, neighbour pairs among them
    hot_cells[0] = idx_t'(0);
    hot_cells[1] = idx_t'(1);
    hot_cells[2] = idx_t'(6);
    hot_cells[3] = idx_t'(7);
    hot_cells[4] = idx_t'(CELLS - 2);
    hot_cells[5] = idx_t'(CELLS - 1);
    hot_cells[6] = idx_t'($urandom);
    hot_cells[7] = hot_cells[6] ^ idx_t'(1);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_high[i] = {$urandom, $urandom};
      pool_high[i][63 -: INDEX_BITS] = hot_cells[i % 8];
      pool_middle[i] = {$urandom, $urandom};
      pool_low[i] = $urandom;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (busy !== 1'b0) @(posedge clk);

    // directed part, reset value of max_quality
    send_request(make_req(MODE_LOOKUP, NEIGHBOUR_HIGH, ID_MID, ID_LOW, GOOD_ADDR, GOOD_PORT,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_ADD, ID_A_HIGH, ID_MID, ID_LOW, GOOD_ADDR, GOOD_PORT,
                          8'd255, 8'sd0, 32'd0));
    send_request(make_req(MODE_LOOKUP, NEIGHBOUR_HIGH, 64'd0, 32'd0, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_LOOKUP, ID_A_HIGH, 64'd0, 32'd0, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_ADD, ID_B_HIGH, ID_MID, ID_LOW, GOOD_ADDR, PORT_MIN,
                          8'd255, 8'sd0, 32'd0));
    send_request(make_req(MODE_ADD, ID_B_HIGH, ID_MID, ID_LOW, 32'hffff_ffff, 16'hffff,
                          8'd255, 8'sd0, 32'd0));
    send_request(make_req(MODE_ADD, ID_B_HIGH, ID_MID, ID_LOW, 32'hc0a8_0101, PORT_MIN + 16'd1,
                          8'd255, 8'sd0, 32'd0));
    send_request(make_req(MODE_ADD, ID_B_HIGH, ID_MID, ID_LOW, GOOD_ADDR, PORT_MIN + 16'd1,
                          8'd0, 8'sd0, 32'hffff_ffff));
    send_request(make_req(MODE_ADD, ID_B_HIGH, ID_MID, ID_LOW, GOOD_ADDR, PORT_MIN + 16'd1,
                          8'd0, 8'sd0, 32'hffff_8000));
    send_request(make_req(MODE_REPLACE, ID_A_HIGH, ID_MID, ID_LOW, 32'h0a00_0001, GOOD_PORT,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_REPLACE, 64'd0, ID_MID, ID_LOW, GOOD_ADDR, GOOD_PORT,
                          8'd20, 8'sd0, 32'd0));
    send_request(make_req(MODE_REPLACE, ID_A_HIGH, ID_MID, ID_LOW, GOOD_ADDR, GOOD_PORT,
                          8'd200, 8'sd0, 32'd0));
    send_request(make_req(MODE_ADJUST, ID_A_HIGH, ID_MID, ID_LOW, 32'd0, 16'd0,
                          8'd0, 8'sd127, 32'd0));
    send_request(make_req(MODE_ADJUST, ID_A_HIGH, ID_MID, ID_LOW, 32'd0, 16'd0,
                          8'd0, -8'sd15, 32'd0));
    send_request(make_req(MODE_ADJUST, ID_A_HIGH, ID_MID, ID_LOW, 32'd0, 16'd0,
                          8'd0, -8'sd1, 32'd0));
    send_request(make_req(MODE_ADJUST, ID_A_HIGH, ID_MID, ~ID_LOW, 32'd0, 16'd0,
                          8'd0, -8'sd128, 32'd0));
    send_request(make_req(MODE_REMOVE, ID_A_HIGH, ~ID_MID, ID_LOW, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_LOOKUP, ID_A_HIGH, 64'd0, 32'd0, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_REMOVE, ID_A_HIGH, ID_MID, ID_LOW, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_LOOKUP, NEIGHBOUR_HIGH, 64'd0, 32'd0, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_UNUSED, ID_A_HIGH, ID_MID, ID_LOW, GOOD_ADDR, GOOD_PORT,
                          8'd255, 8'sd127, 32'hffff_ffff));
    send_request(make_req(MODE_ADD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                          32'hffff_ffff, 32'hc000_0101, 16'hffff, 8'hff, 8'sd127,
                          32'hffff_ffff));
    send_request(make_req(MODE_LOOKUP, 64'hffe0_0000_0000_0000, 64'd0, 32'd0, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    send_request(make_req(MODE_ADD, 64'd0, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff,
                          GOOD_ADDR, GOOD_PORT, 8'd10, 8'sd0, 32'd0));
    send_request(make_req(MODE_LOOKUP, 64'd0, 64'd0, 32'd0, 32'd0, 16'd0,
                          8'd0, 8'sd0, 32'd0));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_max_quality((PHASE_QUALITY[p] < 0) ? 5'($urandom) : 5'(PHASE_QUALITY[p]));
      sender_idle_pct = PHASE_IDLE[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request());
        if ($urandom_range(0, 99) < 2) wait_drained();
      end
      wait_drained();
    end

    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
